// File: sv/aging_route_table_core_macros.svh
// ----------------------------------------------------------------------------
// aging route table assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef AGING_ROUTE_TABLE_CORE_MACROS_SVH
`define AGING_ROUTE_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ART_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ART_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/art_pkg.sv
// ----------------------------------------------------------------------------
// aging route table package
// sizes, request and status codes, and the structs shared by the cell chain
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int ENTRIES      = 64;
	localparam int KEY_BITS     = 64;
	localparam int CFG_IDX_BITS = 8;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FRESH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPIRE = CFG_IDX_BITS'(1);

	localparam logic [31:0] FRESH_RESET  = 32'd60;
	localparam logic [31:0] EXPIRE_RESET = 32'd100;

	localparam logic [1:0] STAT_PROGRESS = 2'd0;
	localparam logic [1:0] STAT_FOUND    = 2'd1;
	localparam logic [1:0] STAT_NFOUND   = 2'd2;
	localparam logic [1:0] STAT_ILLEGAL  = 2'd3;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_UPDATE = 3'd1,
		OP_FIND   = 3'd2,
		OP_PING   = 3'd3,
		OP_CHECK  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_LOOK,
		FSM_WALK,
		FSM_FIN
	} fsm_t;

	// request broadcast to every cell
	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] key;
		logic [31:0]         code;
		logic [1:0]          status;
		logic [KEY_BITS-1:0] node;
		logic [31:0]         addr;
		logic [31:0]         now;
		logic [31:0]         fresh_win;
		logic [31:0]         expire_win;
	} req_t;

	// token handed from cell to cell
	typedef struct packed {
		logic                valid;
		logic                claimed;
		logic                hit;
		logic [1:0]          status;
		logic [31:0]         code;
		logic [KEY_BITS-1:0] node;
		logic [31:0]         addr;
		logic [31:0]         stamp;
	} tok_t;

endpackage

// File: sv/art_cell.sv
// ----------------------------------------------------------------------------
// aging route table cell
// one table entry; acts on the request when the token passes and hands it on
// ----------------------------------------------------------------------------
module art_cell
	import art_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic any_match,
	input  tok_t tok_in,
	output tok_t tok_out,
	output logic match
);

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [1:0]          status_q;
	logic [31:0]         code_q;
	logic [KEY_BITS-1:0] node_q;
	logic [31:0]         addr_q;
	logic [31:0]         stamp_q;
	tok_t                tok_q;

	logic                n_valid;
	logic [KEY_BITS-1:0] n_key;
	logic [1:0]          n_status;
	logic [31:0]         n_code;
	logic [KEY_BITS-1:0] n_node;
	logic [31:0]         n_addr;
	logic [31:0]         n_stamp;
	logic [31:0]         age;
	logic                fresh;
	logic                expired;
	logic                show;
	logic                set_hit;
	logic                claim;
	tok_t                tok_next;

	assign match   = valid_q && (key_q == req.key);
	assign tok_out = tok_q;

	always_comb begin
		age      = req.now - stamp_q;
		fresh    = age <= req.fresh_win;
		expired  = age > req.expire_win;
		n_valid  = valid_q;
		n_key    = key_q;
		n_status = status_q;
		n_code   = code_q;
		n_node   = node_q;
		n_addr   = addr_q;
		n_stamp  = stamp_q;
		show     = 1'b0;
		set_hit  = 1'b0;
		claim    = 1'b0;
		case (req.op)
			OP_ADD: begin
				if (match || (!any_match && !valid_q && !tok_in.claimed)) begin
					show = 1'b1;
					if (match && fresh) begin
						n_status = req.status;
					end else begin
						claim    = !match;
						n_valid  = 1'b1;
						n_key    = req.key;
						n_status = req.status;
						n_code   = req.code;
						n_node   = '0;
						n_addr   = '0;
						n_stamp  = req.now;
					end
				end
			end
			OP_UPDATE: begin
				if (match) begin
					show    = 1'b1;
					set_hit = 1'b1;
					n_stamp = req.now;
					if (code_q != req.code) begin
						n_status = STAT_NFOUND;
					end else begin
						n_node   = req.node;
						n_addr   = req.addr;
						n_status = STAT_FOUND;
					end
				end
			end
			OP_FIND: begin
				show    = match;
				set_hit = match;
			end
			OP_PING: begin
				if (match) begin
					show    = 1'b1;
					set_hit = 1'b1;
					n_stamp = req.now;
				end
			end
			OP_CHECK: begin
				if (valid_q && !fresh) begin
					if (status_q == STAT_PROGRESS) begin
						n_status = STAT_NFOUND;
						n_stamp  = req.now;
					end else if (expired) begin
						n_valid = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		tok_next = tok_in;
		if (claim) begin
			tok_next.claimed = 1'b1;
		end
		if (set_hit) begin
			tok_next.hit = 1'b1;
		end
		if (show) begin
			tok_next.status = n_status;
			tok_next.code   = n_code;
			tok_next.node   = n_node;
			tok_next.addr   = n_addr;
			tok_next.stamp  = n_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_next;
			if (tok_in.valid) begin
				valid_q <= n_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			key_q    <= n_key;
			status_q <= n_status;
			code_q   <= n_code;
			node_q   <= n_node;
			addr_q   <= n_addr;
			stamp_q  <= n_stamp;
		end
	end

endmodule

// File: sv/aging_route_table_core.sv
// ----------------------------------------------------------------------------
// aging route table core
// keyed route table with timestamps and aging, built as a chain of entry cells
// ----------------------------------------------------------------------------
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  request | in_valid in_ready req_type key req_code new_status | in
//          | node_key node_addr now                             |
//  result  | out_valid out_ready hit table_full entry_*         | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data             | in
//
//  an item passes from request transfer through LOOK, then WALK, where the
//  token steps through the cell chain one cell per cycle, then FIN to result
//  reset clears all valid bits and loads the window registers at once
//  a result held by out_ready low keeps the block from finishing the next item
// ----------------------------------------------------------------------------
module aging_route_table_core
	import art_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              req_type,
	input  logic [63:0]             key,
	input  logic [31:0]             req_code,
	input  logic [1:0]              new_status,
	input  logic [63:0]             node_key,
	input  logic [31:0]             node_addr,
	input  logic [31:0]             now,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic                    table_full,
	output logic [1:0]              entry_state,
	output logic [31:0]             entry_code,
	output logic [63:0]             entry_node,
	output logic [31:0]             entry_addr,
	output logic [31:0]             entry_stamp,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_data
);

	fsm_t               state_q;
	fsm_t               state_d;
	logic [31:0]        fresh_q;
	logic [31:0]        expire_q;
	req_t               req_q;
	req_t               req_b;
	logic               launch_q;
	logic               any_match_q;
	logic [ENTRIES-1:0] match_vec;
	tok_t               head_tok;
	tok_t               links [ENTRIES+1];
	tok_t               fin_q;
	logic               out_load;
	logic               r_hit;
	logic               r_full;
	logic               out_valid_q;
	logic               hit_q;
	logic               full_q;
	logic [1:0]         state_out_q;
	logic [31:0]        code_out_q;
	logic [63:0]        node_out_q;
	logic [31:0]        addr_out_q;
	logic [31:0]        stamp_out_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		req_b            = req_q;
		req_b.fresh_win  = fresh_q;
		req_b.expire_win = expire_q;
		head_tok         = '0;
		head_tok.valid   = launch_q;
	end

	assign links[0] = head_tok;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		art_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.req       (req_b),
			.any_match (any_match_q),
			.tok_in    (links[g]),
			.tok_out   (links[g+1]),
			.match     (match_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = FSM_LOOK;
				end
			end
			FSM_LOOK: begin
				state_d = FSM_WALK;
			end
			FSM_WALK: begin
				if (links[ENTRIES].valid) begin
					state_d = FSM_FIN;
				end
			end
			FSM_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q  <= FRESH_RESET;
			expire_q <= EXPIRE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRESH:  fresh_q  <= cfg_data;
				CFG_EXPIRE: expire_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= (state_q == FSM_LOOK);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q.op         <= op_t'(req_type);
			req_q.key        <= key[KEY_BITS-1:0];
			req_q.code       <= req_code;
			req_q.status     <= (new_status == STAT_ILLEGAL) ? STAT_NFOUND : new_status;
			req_q.node       <= node_key[KEY_BITS-1:0];
			req_q.addr       <= node_addr;
			req_q.now        <= now;
			req_q.fresh_win  <= fresh_q;
			req_q.expire_win <= expire_q;
		end
		if (state_q == FSM_LOOK) begin
			any_match_q <= |match_vec;
		end
		if (state_q == FSM_WALK && links[ENTRIES].valid) begin
			fin_q <= links[ENTRIES];
		end
		if (out_load) begin
			hit_q       <= r_hit;
			full_q      <= r_full;
			state_out_q <= fin_q.status;
			code_out_q  <= fin_q.code;
			node_out_q  <= 64'(fin_q.node);
			addr_out_q  <= fin_q.addr;
			stamp_out_q <= fin_q.stamp;
		end
	end

	always_comb begin
		r_hit  = 1'b0;
		r_full = 1'b0;
		case (req_q.op)
			OP_ADD: begin
				r_hit  = 1'b1;
				r_full = !any_match_q && !fin_q.claimed;
			end
			OP_UPDATE, OP_FIND, OP_PING: begin
				r_hit = fin_q.hit;
			end
			OP_CHECK: begin
				r_hit = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign table_full  = full_q;
	assign entry_state = state_out_q;
	assign entry_code  = code_out_q;
	assign entry_node  = node_out_q;
	assign entry_addr  = addr_out_q;
	assign entry_stamp = stamp_out_q;

endmodule

// File: sv/art_checker.sv
// ----------------------------------------------------------------------------
// aging route table port checker
// watches the top level ports for handshake and result consistency
// ----------------------------------------------------------------------------
`include "aging_route_table_core_macros.svh"

module art_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit,
	input logic        table_full,
	input logic [1:0]  entry_state,
	input logic [31:0] entry_code,
	input logic [31:0] entry_addr,
	input logic [31:0] entry_stamp
);

	// block stays busy for the lookup and launch cycles after a transfer
	`ART_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready ##1 !in_ready, "request taken while busy")

	// a stalled result holds
	`ART_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(entry_code), "stalled result changed")

	// dropped add shows an empty entry
	`ART_ASSERT_NOW(a_full_fields, out_valid && table_full, hit && entry_code == 32'd0 && entry_stamp == 32'd0, "dropped add shows entry data")

	// a miss shows an empty entry
	`ART_ASSERT_NOW(a_miss_zero, out_valid && !hit, !table_full && entry_state == 2'd0 && entry_code == 32'd0 && entry_addr == 32'd0, "miss shows entry data")

endmodule

bind aging_route_table_core art_checker u_art_checker (.*);
